// File: rtl/rnwh_pkg.sv
// ----------------------------------------------------------------------------
// rnwh_pkg
// Types and constants of the nearest wall hit ray caster.
// ----------------------------------------------------------------------------
`default_nettype none

package rnwh_pkg;

    localparam int COORD_WIDTH = 16;                      // coordinate width, Q12.4 at 16
    localparam int DIR_W       = 16;                      // direction, Q1.14
    localparam int DIFF_W      = COORD_WIDTH + 1;         // coordinate difference
    localparam int OP_W        = (DIFF_W > DIR_W) ? DIFF_W : DIR_W;
    localparam int PROD_W      = 2 * OP_W;
    localparam int DEN_W       = PROD_W;                  // den and t numerator
    localparam int UN_W        = PROD_W + 1;              // u numerator
    localparam int QUO_W       = 16;                      // quotient bits of the divider
    localparam int DIST_FRAC   = 14;                      // undo the Q1.14 direction scale
    localparam int SENSE_FRAC  = 15;                      // Q1.15 sensor scale
    localparam int DIV_W       = UN_W + QUO_W;
    localparam int DIV_CNT_W   = $clog2(QUO_W + 1);
    localparam int RANGE_W     = 15;
    localparam int SENSE_W     = 16;

    localparam logic [SENSE_W-1:0] ONE_Q15  = 16'h8000;
    localparam logic [QUO_W-1:0]   DIST_SAT = 16'hFFFF;

    localparam logic [RANGE_W-1:0] SIGHT_RESET = 15'd1600;
    localparam logic [RANGE_W-1:0] TOUCH_RESET = 15'd109;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RANGE_W;
    localparam logic [CFG_IDX_W-1:0] REG_SIGHT_RANGE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_DISTANCE = 1'd1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ray_x;
        logic signed [COORD_WIDTH-1:0] ray_y;
        logic signed [DIR_W-1:0]       dir_x;
        logic signed [DIR_W-1:0]       dir_y;
        logic signed [COORD_WIDTH-1:0] wall_ax;
        logic signed [COORD_WIDTH-1:0] wall_ay;
        logic signed [COORD_WIDTH-1:0] wall_bx;
        logic signed [COORD_WIDTH-1:0] wall_by;
        logic                          last_wall;
    } in_t;

    typedef struct packed {
        logic                 hit_found;
        logic [RANGE_W-1:0]   hit_distance;
        logic [SENSE_W-1:0]   sensor_value;
        logic                 contact;
    } out_t;

endpackage

`default_nettype wire

// File: rtl/ray_nearest_wall_hit_top.sv
// ----------------------------------------------------------------------------
// ray_nearest_wall_hit_top
// Ray caster: intersects one ray with one wall per transfer, keeps the nearest
// hit and a contact flag, and reports them on the ray's last wall.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid/s_ready    in_t  (ray, direction, wall, last_wall)
//  m_*          out  m_valid/m_ready    out_t (hit, distance, sensor, contact)
//  cfg_*        in   cfg_we             cfg_index, cfg_wdata
//
//  A wall passes the transfer, the shared multiplier (six products, one accumulate), a
//  hit test and, only on a hit, the restoring divider and an update. The last wall adds
//  the sensor division (skipped when no hit is stored) and a load of the output.
//  The output register frees the input side while a result waits on m_ready; a second
//  last wall holds in its load cycle until then. Reset is synchronous, no clearing pass.
//
`default_nettype none

module ray_nearest_wall_hit_top (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  rnwh_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  wire                            m_ready,
    output rnwh_pkg::out_t                 m_data,
    input  wire                            cfg_we,
    input  wire [rnwh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [rnwh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rnwh_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_TEST = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_UPD  = 7'b0010000,
        ST_NORM = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    localparam logic [2:0] STEP_DEN_A = 3'd0;
    localparam logic [2:0] STEP_DEN_B = 3'd1;
    localparam logic [2:0] STEP_TN_A  = 3'd2;
    localparam logic [2:0] STEP_TN_B  = 3'd3;
    localparam logic [2:0] STEP_UN_A  = 3'd4;
    localparam logic [2:0] STEP_UN_B  = 3'd5;
    localparam logic [2:0] STEP_LAST  = 3'd6;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W);

    // control
    state_t                 state_reg, state_next;
    logic [2:0]             mul_cnt_reg, mul_cnt_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   div_sense_reg, div_sense_next;
    logic                   best_valid_reg, best_valid_next;
    logic                   touch_seen_reg, touch_seen_next;
    logic                   m_valid_reg, m_valid_next;
    logic [RANGE_W-1:0]     sight_reg, sight_next;
    logic [RANGE_W-1:0]     touch_reg, touch_next;

    // datapath
    logic signed [DIFF_W-1:0] a_reg, a_next;   // ay - by
    logic signed [DIFF_W-1:0] b_reg, b_next;   // ax - bx
    logic signed [DIFF_W-1:0] c_reg, c_next;   // ay - ray_y
    logic signed [DIFF_W-1:0] e_reg, e_next;   // ax - ray_x
    logic signed [DIR_W-1:0]  dx_reg, dx_next;
    logic signed [DIR_W-1:0]  dy_reg, dy_next;
    logic                     last_reg, last_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DEN_W-1:0]  den_reg, den_next;
    logic signed [DEN_W-1:0]  tn_reg, tn_next;
    logic signed [UN_W-1:0]   un_reg, un_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [DIV_W-1:0]         dsh_reg, dsh_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic                     sat_reg, sat_next;
    logic [RANGE_W-1:0]       best_reg, best_next;
    logic [SENSE_W-1:0]       sense_reg, sense_next;
    out_t                     out_reg, out_next;

    // shared multiplier operands
    logic signed [OP_W-1:0]   mul_a, mul_b;

    // hit test
    logic                     den_zero, den_neg, tn_neg, tn_zero, un_neg, un_zero;
    logic                     t_ok, hit;
    logic [DEN_W-1:0]         den_mag;
    logic [UN_W-1:0]          un_mag;

    // divider step
    logic                     div_ge;
    logic [DIV_W-1:0]         div_diff;

    // distance update
    logic [QUO_W-1:0]         hit_dist;
    logic                     dist_in_sight, dist_closer, dist_touch;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        case (mul_cnt_reg)
            STEP_DEN_A: begin
                mul_a = OP_W'(a_reg);
                mul_b = OP_W'(dx_reg);
            end
            STEP_DEN_B: begin
                mul_a = OP_W'(b_reg);
                mul_b = OP_W'(dy_reg);
            end
            STEP_TN_A: begin
                mul_a = OP_W'(c_reg);
                mul_b = OP_W'(dx_reg);
            end
            STEP_TN_B: begin
                mul_a = OP_W'(e_reg);
                mul_b = OP_W'(dy_reg);
            end
            STEP_UN_A: begin
                mul_a = OP_W'(a_reg);
                mul_b = OP_W'(e_reg);
            end
            STEP_UN_B: begin
                mul_a = OP_W'(b_reg);
                mul_b = OP_W'(c_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        den_zero = (den_reg == '0);
        den_neg  = den_reg[DEN_W-1];
        tn_neg   = tn_reg[DEN_W-1];
        tn_zero  = (tn_reg == '0);
        un_neg   = un_reg[UN_W-1];
        un_zero  = (un_reg == '0);
        t_ok     = den_neg ? (tn_neg && (tn_reg > den_reg))
                           : (!tn_neg && !tn_zero && (tn_reg < den_reg));
        hit      = !den_zero && t_ok && !un_zero && (un_neg == den_neg);
        den_mag  = den_neg ? DEN_W'(-den_reg) : DEN_W'(den_reg);
        un_mag   = un_neg ? UN_W'(-un_reg) : UN_W'(un_reg);
    end

    assign div_ge   = (rem_reg >= dsh_reg);
    assign div_diff = rem_reg - dsh_reg;

    always_comb begin
        hit_dist      = sat_reg ? DIST_SAT : quo_reg;
        dist_in_sight = (hit_dist < {1'b0, sight_reg});
        dist_closer   = !best_valid_reg || (hit_dist < {1'b0, best_reg});
        dist_touch    = (hit_dist <= {1'b0, touch_reg});
    end

    always_comb begin
        state_next      = state_reg;
        mul_cnt_next    = mul_cnt_reg;
        div_cnt_next    = div_cnt_reg;
        div_sense_next  = div_sense_reg;
        best_valid_next = best_valid_reg;
        touch_seen_next = touch_seen_reg;
        m_valid_next    = m_valid_reg;
        sight_next      = sight_reg;
        touch_next      = touch_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        e_next          = e_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        last_next       = last_reg;
        prod_next       = prod_reg;
        den_next        = den_reg;
        tn_next         = tn_reg;
        un_next         = un_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        quo_next        = quo_reg;
        sat_next        = sat_reg;
        best_next       = best_reg;
        sense_next      = sense_reg;
        out_next        = out_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_index)
                REG_SIGHT_RANGE:    sight_next = cfg_wdata;
                REG_TOUCH_DISTANCE: touch_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next       = DIFF_W'(s_data.wall_ay) - DIFF_W'(s_data.wall_by);
                    b_next       = DIFF_W'(s_data.wall_ax) - DIFF_W'(s_data.wall_bx);
                    c_next       = DIFF_W'(s_data.wall_ay) - DIFF_W'(s_data.ray_y);
                    e_next       = DIFF_W'(s_data.wall_ax) - DIFF_W'(s_data.ray_x);
                    dx_next      = s_data.dir_x;
                    dy_next      = s_data.dir_y;
                    last_next    = s_data.last_wall;
                    mul_cnt_next = STEP_DEN_A;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
                // accumulate the product registered in the previous step
                case (mul_cnt_reg)
                    STEP_DEN_B: den_next = DEN_W'(prod_reg);
                    STEP_TN_A:  den_next = den_reg - DEN_W'(prod_reg);
                    STEP_TN_B:  tn_next  = DEN_W'(prod_reg);
                    STEP_UN_A:  tn_next  = tn_reg - DEN_W'(prod_reg);
                    STEP_UN_B:  un_next  = UN_W'(prod_reg);
                    STEP_LAST:  un_next  = un_reg - UN_W'(prod_reg);
                    default: ;
                endcase
                if (mul_cnt_reg == STEP_LAST) begin
                    state_next = ST_TEST;
                end else begin
                    mul_cnt_next = mul_cnt_reg + 3'd1;
                end
            end
            ST_TEST: begin
                if (hit) begin
                    rem_next       = DIV_W'(un_mag) << DIST_FRAC;
                    dsh_next       = DIV_W'(den_mag) << QUO_W;
                    quo_next       = '0;
                    div_cnt_next   = '0;
                    div_sense_next = 1'b0;
                    state_next     = ST_DIV;
                end else if (last_reg) begin
                    state_next = ST_NORM;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                // first step only checks for quotient overflow
                if (div_cnt_reg == '0) begin
                    sat_next = div_ge;
                end else begin
                    quo_next = {quo_reg[QUO_W-2:0], div_ge};
                    if (div_ge) begin
                        rem_next = div_diff;
                    end
                end
                dsh_next = dsh_reg >> 1;
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_UPD;
                end else begin
                    div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                end
            end
            ST_UPD: begin
                if (div_sense_reg) begin
                    if (sat_reg || (quo_reg > ONE_Q15)) begin
                        sense_next = ONE_Q15;
                    end else begin
                        sense_next = quo_reg;
                    end
                    state_next = ST_EMIT;
                end else begin
                    if (dist_in_sight && dist_closer) begin
                        best_next       = hit_dist[RANGE_W-1:0];
                        best_valid_next = 1'b1;
                    end
                    if (dist_touch) begin
                        touch_seen_next = 1'b1;
                    end
                    state_next = last_reg ? ST_NORM : ST_IDLE;
                end
            end
            ST_NORM: begin
                if (best_valid_reg) begin
                    rem_next       = DIV_W'(best_reg) << SENSE_FRAC;
                    dsh_next       = DIV_W'(sight_reg) << QUO_W;
                    quo_next       = '0;
                    div_cnt_next   = '0;
                    div_sense_next = 1'b1;
                    state_next     = ST_DIV;
                end else begin
                    sense_next = ONE_Q15;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.hit_found    = best_valid_reg;
                    out_next.hit_distance = best_valid_reg ? best_reg : '0;
                    out_next.sensor_value = sense_reg;
                    out_next.contact      = touch_seen_reg;
                    m_valid_next          = 1'b1;
                    best_valid_next       = 1'b0;
                    touch_seen_next       = 1'b0;
                    best_next             = '0;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mul_cnt_reg    <= '0;
            div_cnt_reg    <= '0;
            div_sense_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            touch_seen_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            sight_reg      <= SIGHT_RESET;
            touch_reg      <= TOUCH_RESET;
        end else begin
            state_reg      <= state_next;
            mul_cnt_reg    <= mul_cnt_next;
            div_cnt_reg    <= div_cnt_next;
            div_sense_reg  <= div_sense_next;
            best_valid_reg <= best_valid_next;
            touch_seen_reg <= touch_seen_next;
            m_valid_reg    <= m_valid_next;
            sight_reg      <= sight_next;
            touch_reg      <= touch_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        e_reg     <= e_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        last_reg  <= last_next;
        prod_reg  <= prod_next;
        den_reg   <= den_next;
        tn_reg    <= tn_next;
        un_reg    <= un_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quo_reg   <= quo_next;
        sat_reg   <= sat_next;
        best_reg  <= best_next;
        sense_reg <= sense_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

// File: rtl/rnwh_checker.sv
// ----------------------------------------------------------------------------
// rnwh_checker
// Port level checks of the ray caster, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rnwh_checker (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    input  wire                            s_ready,
    input  wire                            m_valid,
    input  wire                            m_ready,
    input  rnwh_pkg::out_t                 m_data
);
    import rnwh_pkg::*;

    // a stalled result transfer holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one wall at a time: the input closes after each transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input open right after a transfer");

    // no hit reports zero distance and a full-scale sensor
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit_found |->
            m_data.hit_distance == '0 && m_data.sensor_value == ONE_Q15)
        else $error("no-hit result malformed");

    // sensor never exceeds 1.0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.sensor_value <= ONE_Q15)
        else $error("sensor above full scale");

endmodule

bind ray_nearest_wall_hit_top rnwh_checker u_rnwh_checker (.*);

`default_nettype wire

// File: verif/ray_nearest_wall_hit_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_nearest_wall_hit_chk
// Watches the wall, result and register ports of the ray caster. It traces
// every accepted wall against its own copy of the ranges and of the nearest-hit
// state, queues the sensor reading due on each last wall, and compares every
// result transfer field by field with the oldest reading in the queue.
// ----------------------------------------------------------------------------

module ray_nearest_wall_hit_chk (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    input  wire                            s_ready,
    input  rnwh_pkg::in_t                  s_data,
    input  wire                            m_valid,
    input  wire                            m_ready,
    input  rnwh_pkg::out_t                 m_data,
    input  wire                            cfg_we,
    input  wire [rnwh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [rnwh_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             readings_due
);
    import rnwh_pkg::*;

    logic [RANGE_W-1:0] sight_q = SIGHT_RESET;
    logic [RANGE_W-1:0] touch_q = TOUCH_RESET;
    logic [QUO_W-1:0]   near_dist = '0;
    logic               near_valid = 1'b0;
    logic               touch_hit = 1'b0;
    out_t               due_readings[$];
    int                 bad_count = 0;
    int                 queued = 0;

    assign mismatches   = bad_count;
    assign readings_due = queued;

    // distance along the ray in Q12.4, returns 0 when the wall is missed
    function automatic bit wall_hit_distance(input in_t w, output logic [QUO_W-1:0] hit_dist);
        longint x3 = longint'(w.ray_x);
        longint y3 = longint'(w.ray_y);
        longint dx = longint'(w.dir_x);
        longint dy = longint'(w.dir_y);
        longint x1 = longint'(w.wall_ax);
        longint y1 = longint'(w.wall_ay);
        longint x2 = longint'(w.wall_bx);
        longint y2 = longint'(w.wall_by);
        longint den, tn, un;
        longint unsigned num, mden, quo;
        bit t_ok;
        hit_dist = '0;
        den = (y1 - y2) * dx - (x1 - x2) * dy;
        tn  = (y1 - y3) * dx - (x1 - x3) * dy;
        un  = (y1 - y2) * (x1 - x3) - (x1 - x2) * (y1 - y3);
        if (den == 0)
            return 1'b0;
        t_ok = (den > 0) ? (tn > 0 && tn < den) : (tn < 0 && tn > den);
        if (!t_ok || un == 0 || ((un < 0) != (den < 0)))
            return 1'b0;
        // direction is Q1.14, so scale the numerator back before dividing
        num  = longint'(un < 0 ? -un : un) << DIST_FRAC;
        mden = longint'(den < 0 ? -den : den);
        quo  = num / mden;
        hit_dist = (quo > 64'(DIST_SAT)) ? DIST_SAT : quo[QUO_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        in_t                w;
        out_t               got, want, res;
        logic [QUO_W-1:0]   d;
        longint unsigned    sense;
        if (!aresetn) begin
            sight_q    = SIGHT_RESET;
            touch_q    = TOUCH_RESET;
            near_dist  = '0;
            near_valid = 1'b0;
            touch_hit  = 1'b0;
            due_readings.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_SIGHT_RANGE)
                    sight_q = cfg_wdata;
                else if (cfg_index == REG_TOUCH_DISTANCE)
                    touch_q = cfg_wdata;
            end

            if (m_valid && m_ready) begin
                got = m_data;
                if (due_readings.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: unexpected result hit=%0d dist=%0d sensor=%0d contact=%0d",
                                 $time, got.hit_found, got.hit_distance, got.sensor_value,
                                 got.contact);
                end else begin
                    want = due_readings.pop_front();
                    if (got.hit_found !== want.hit_found ||
                        got.hit_distance !== want.hit_distance ||
                        got.sensor_value !== want.sensor_value ||
                        got.contact !== want.contact) begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"%0t: result mismatch, expected hit=%0d dist=%0d ",
                                      "sensor=%0d contact=%0d, got hit=%0d dist=%0d ",
                                      "sensor=%0d contact=%0d"},
                                     $time, want.hit_found, want.hit_distance,
                                     want.sensor_value, want.contact, got.hit_found,
                                     got.hit_distance, got.sensor_value, got.contact);
                    end
                end
            end

            if (s_valid && s_ready) begin
                w = s_data;
                if (wall_hit_distance(w, d)) begin
                    // only a strictly closer hit replaces the stored one
                    if (d < 16'(sight_q) && (!near_valid || d < near_dist)) begin
                        near_dist  = d;
                        near_valid = 1'b1;
                    end
                    if (d <= 16'(touch_q))
                        touch_hit = 1'b1;
                end
                if (w.last_wall) begin
                    sense = 64'(ONE_Q15);
                    if (near_valid && sight_q != 0) begin
                        sense = (64'(near_dist) << SENSE_FRAC) / 64'(sight_q);
                        if (sense > 64'(ONE_Q15))
                            sense = 64'(ONE_Q15);
                    end
                    res.hit_found    = near_valid;
                    res.hit_distance = near_valid ? near_dist[RANGE_W-1:0] : '0;
                    res.sensor_value = sense[SENSE_W-1:0];
                    res.contact      = touch_hit;
                    due_readings = {due_readings, res};
                    near_dist  = '0;
                    near_valid = 1'b0;
                    touch_hit  = 1'b0;
                end
            end
        end
        queued <= due_readings.size();
    end

endmodule

// File: verif/ray_nearest_wall_hit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_nearest_wall_hit_top_tb
// Drives the ray caster with directed walls for the corner cases, then with
// random rays built to hit, miss and graze their walls under several range
// settings, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------

module ray_nearest_wall_hit_top_tb;
    import rnwh_pkg::*;

    localparam int UNIT          = 16384;
    localparam int CMAX          = 2 ** (COORD_WIDTH - 1) - 1;
    localparam int CMIN          = -(2 ** (COORD_WIDTH - 1));
    localparam int RMAX          = 2 ** RANGE_W - 1;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_WALLS   = 150;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_t                    s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_t                   m_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_SIGHT_RANGE;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int mismatch_count;
    int readings_due;
    bit quiet_tail = 1'b0;
    int holds_asked = 0;
    int holds_done = 0;
    int walls_sent = 0;
    int sight_now = int'(SIGHT_RESET);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ray_nearest_wall_hit_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ray_nearest_wall_hit_chk hit_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatch_count),
        .readings_due (readings_due)
    );

    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(input int v);
        if (v > CMAX)
            return CMAX[COORD_WIDTH-1:0];
        if (v < CMIN)
            return CMIN[COORD_WIDTH-1:0];
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic in_t wall_item(input int rx, input int ry, input int dx, input int dy,
                                      input int ax, input int ay, input int bx, input int by,
                                      input bit last);
        in_t w;
        w.ray_x     = clamp_coord(rx);
        w.ray_y     = clamp_coord(ry);
        w.dir_x     = dx[DIR_W-1:0];
        w.dir_y     = dy[DIR_W-1:0];
        w.wall_ax   = clamp_coord(ax);
        w.wall_ay   = clamp_coord(ay);
        w.wall_bx   = clamp_coord(bx);
        w.wall_by   = clamp_coord(by);
        w.last_wall = last;
        return w;
    endfunction

    task automatic send_wall(input in_t w, input bit calm);
        if (!calm && !quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        walls_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // ranges change only once every reading is out and the last wall has drained
    task automatic program_ranges(input int sight, input int touch);
        s_valid <= 1'b0;
        do @(posedge aclk); while (readings_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SIGHT_RANGE;
        cfg_wdata <= sight[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= REG_TOUCH_DISTANCE;
        cfg_wdata <= touch[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        sight_now = sight;
    endtask

    task automatic cast_ray();
        int  ox, oy, dx, dy, nw, d, px, py, l1, l2, kind, span;
        real ang;
        bit  calm;
        in_t w;
        calm = ($urandom_range(0, 3) == 0);
        nw   = $urandom_range(1, 6);
        ox   = int'($urandom_range(0, 16000)) - 8000;
        oy   = int'($urandom_range(0, 16000)) - 8000;
        if ($urandom_range(0, 7) == 0) begin
            dx = int'($urandom_range(0, 2 * UNIT)) - UNIT;
            dy = int'($urandom_range(0, 2 * UNIT)) - UNIT;
        end else begin
            ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
            dx  = $rtoi($cos(ang) * UNIT);
            dy  = $rtoi($sin(ang) * UNIT);
        end
        span = sight_now + sight_now / 2 + 64;
        if (span > 20000)
            span = 20000;
        for (int i = 0; i < nw; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                // noise: every field random
                w.ray_x   = COORD_WIDTH'($urandom);
                w.ray_y   = COORD_WIDTH'($urandom);
                w.dir_x   = DIR_W'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
                w.dir_y   = DIR_W'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
                w.wall_ax = COORD_WIDTH'($urandom);
                w.wall_ay = COORD_WIDTH'($urandom);
                w.wall_bx = COORD_WIDTH'($urandom);
                w.wall_by = COORD_WIDTH'($urandom);
            end else begin
                // wall across the ray at distance d, behind the origin for kind 9
                d = (kind == 2) ? $urandom_range(0, 300) : $urandom_range(0, span);
                if (kind == 9)
                    d = -d;
                px = ox + d * dx / UNIT;
                py = oy + d * dy / UNIT;
                l1 = $urandom_range(1, 3000);
                l2 = $urandom_range(1, 3000);
                w  = wall_item(ox, oy, dx, dy, px - dy * l1 / UNIT, py + dx * l1 / UNIT,
                               px + dy * l2 / UNIT, py - dx * l2 / UNIT, 1'b0);
            end
            w.last_wall = (i == nw - 1);
            send_wall(w, calm);
        end
    endtask

    // result side: random stalls, one long hold-off on request, none at the tail
    initial begin
        wait (aresetn);
        forever begin
            if (holds_asked > holds_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
        end
    end

    initial begin
        int target;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset ranges: sight 100.0, touch 6.8
        send_wall(wall_item(0, 0, UNIT, 0, 800, -1600, 800, 1600, 1), 1'b0);
        send_wall(wall_item(0, 0, UNIT, 0, 0, 800, 1600, 800, 1), 1'b0);       // parallel
        send_wall(wall_item(0, 0, 0, 0, 800, -1600, 800, 1600, 1), 1'b0);      // no direction
        send_wall(wall_item(0, 0, UNIT, 0, -800, -1600, -800, 1600, 1), 1'b0); // behind
        send_wall(wall_item(0, 0, UNIT, 0, 80, -1600, 80, 1600, 1), 1'b0);     // contact
        send_wall(wall_item(0, 0, 0, UNIT, -100, 900, 100, 900, 0), 1'b0);
        send_wall(wall_item(0, 0, 0, UNIT, -100, 400, 100, 400, 0), 1'b0);
        send_wall(wall_item(0, 0, 0, UNIT, 100, 400, -100, 400, 0), 1'b0);     // tie
        send_wall(wall_item(0, 0, 0, UNIT, -100, 2400, 100, 2400, 1), 1'b0);
        send_wall(wall_item(0, 0, UNIT, 0, 2000, -1600, 2000, 1600, 1), 1'b0); // out of sight
        send_wall(wall_item(0, 0, UNIT, 0, 1, -100, 0, 100, 1), 1'b0);         // below one lsb
        send_wall(wall_item(0, 0, UNIT, 0, 800, 0, 800, 1600, 1), 1'b0);       // endpoint on ray
        send_wall(wall_item(0, 0, UNIT, UNIT, 800, -3200, 800, 3200, 1), 1'b0); // not unit length
        send_wall(wall_item(CMIN, 0, 1, 0, CMAX, CMIN, CMAX, CMAX, 1), 1'b0);  // saturates
        send_wall(wall_item(CMAX, CMAX, -UNIT, -UNIT, CMIN, CMAX, CMAX, CMIN, 1), 1'b0);
        send_wall(wall_item(CMIN, CMIN, UNIT, UNIT, CMIN, CMAX, CMAX, CMIN, 1), 1'b0);
        send_wall(wall_item(0, 0, -UNIT, 0, -800, 1600, -800, -1600, 1), 1'b0);

        // zero sight: hits never count, contact still does
        program_ranges(0, int'(TOUCH_RESET));
        send_wall(wall_item(0, 0, UNIT, 0, 800, -1600, 800, 1600, 0), 1'b0);
        send_wall(wall_item(0, 0, UNIT, 0, 50, -1600, 50, 1600, 1), 1'b0);

        // sight lowered below a stored hit
        program_ranges(RMAX, RMAX);
        send_wall(wall_item(-10000, 0, UNIT, 0, 10000, -1600, 10000, 1600, 0), 1'b0);
        program_ranges(1000, RMAX);
        send_wall(wall_item(0, 0, UNIT, 0, 0, 800, 1600, 800, 1), 1'b0);

        // sight cleared while a hit is stored
        program_ranges(RMAX, 0);
        send_wall(wall_item(0, 0, UNIT, 0, 500, -1600, 500, 1600, 0), 1'b0);
        program_ranges(0, 0);
        send_wall(wall_item(0, 0, UNIT, 0, 0, 800, 1600, 800, 1), 1'b0);

        program_ranges(RMAX, 0);
        send_wall(wall_item(0, 0, UNIT, 0, 1, -100, 0, 100, 1), 1'b0);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: program_ranges(int'(SIGHT_RESET), int'(TOUCH_RESET));
                1: program_ranges(RMAX, 0);
                2: program_ranges(1, RMAX);
                default: program_ranges($urandom_range(1, RMAX), $urandom_range(0, 3000));
            endcase
            if (phase == 3)
                holds_asked++;
            if (phase == 7)
                quiet_tail = 1'b1;
            target = walls_sent + PHASE_WALLS;
            while (walls_sent < target)
                cast_ray();
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (readings_due != 0);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && readings_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/rnwh_pkg.sv
rtl/ray_nearest_wall_hit_top.sv
rtl/rnwh_checker.sv
verif/ray_nearest_wall_hit_chk.sv
verif/ray_nearest_wall_hit_top_tb.sv
